// ===== rtl/core/ipv4hg_pkg.sv =====
package ipv4hg_pkg;

	localparam int ADDR_W  = 32;
	localparam int PROTO_W = 8;
	localparam int LEN_W   = 16;
	localparam int BYTE_W  = 8;
	localparam int IDX_W   = 5;
	localparam int SUM_W   = 20;

	localparam int HDR_BYTES   = 20;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(HDR_BYTES - 1);
	localparam logic [LEN_W-1:0] MAX_PAYLOAD = 16'd65515;
	localparam logic [LEN_W-1:0] HDR_LEN     = 16'(HDR_BYTES);

	localparam logic [7:0]  VER_IHL  = 8'h45;
	localparam logic [7:0]  TOS      = 8'h00;
	localparam logic [15:0] FLAGS_DF = 16'h4000;
	localparam logic [7:0]  TTL      = 8'd64;

	// everything the back end needs to stream one header
	typedef struct packed {
		logic [ADDR_W-1:0]  dest_addr;
		logic [ADDR_W-1:0]  src_addr;
		logic [PROTO_W-1:0] protocol_number;
		logic [LEN_W-1:0]   pkt_len;
		logic [LEN_W-1:0]   ident;
		logic [LEN_W-1:0]   csum;
	} hdr_entry_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctrl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== rtl/core/ipv4hg_ifs.sv =====
interface ipv4hg_req_if;
	logic                              valid;
	logic                              ready;
	logic [ipv4hg_pkg::ADDR_W-1:0]     dest_addr;
	logic [ipv4hg_pkg::PROTO_W-1:0]    protocol_number;
	logic [ipv4hg_pkg::LEN_W-1:0]      payload_length;

	modport source (output valid, dest_addr, protocol_number, payload_length, input ready);
	modport sink   (input valid, dest_addr, protocol_number, payload_length, output ready);
endinterface

interface ipv4hg_hdr_if;
	logic                              valid;
	logic                              ready;
	logic [ipv4hg_pkg::BYTE_W-1:0]     header_byte;
	logic [ipv4hg_pkg::IDX_W-1:0]      byte_index;
	logic                              last_byte;

	modport source (output valid, header_byte, byte_index, last_byte, input ready);
	modport sink   (input valid, header_byte, byte_index, last_byte, output ready);
endinterface

// ===== rtl/core/ipv4hg_front.sv =====
module ipv4hg_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ipv4hg_pkg::ADDR_W-1:0]   cfg_wdata,
	ipv4hg_req_if.sink                      req,
	input  logic                            q_full,
	output logic                            q_push,
	output ipv4hg_pkg::hdr_entry_t          q_wdata
);
	import ipv4hg_pkg::*;

	logic [ADDR_W-1:0] local_addr_q;
	logic [LEN_W-1:0]  ident_q;

	hdr_entry_t        fld_s1;
	logic              valid_s1;
	hdr_entry_t        fld_s2;
	logic [SUM_W-1:0]  sum_s2;
	logic              valid_s2;

	logic              req_xfer;
	logic              move_s12;
	logic [LEN_W-1:0]  plen_sat;
	logic [SUM_W-1:0]  sum_c;
	logic [LEN_W:0]    fold1;
	logic [LEN_W-1:0]  fold2;

	assign q_push    = valid_s2 && !q_full;
	assign move_s12  = valid_s1 && (!valid_s2 || q_push);
	assign req.ready = !valid_s1 || move_s12;
	assign req_xfer  = req.valid && req.ready;

	assign plen_sat = (req.payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD : req.payload_length;

	// ones'-complement sum of the header words, checksum word left out
	assign sum_c = SUM_W'({VER_IHL, TOS}) + SUM_W'(FLAGS_DF)
		+ SUM_W'(fld_s1.pkt_len) + SUM_W'(fld_s1.ident)
		+ SUM_W'({TTL, fld_s1.protocol_number})
		+ SUM_W'(fld_s1.src_addr[31:16]) + SUM_W'(fld_s1.src_addr[15:0])
		+ SUM_W'(fld_s1.dest_addr[31:16]) + SUM_W'(fld_s1.dest_addr[15:0]);

	// two end-around folds are enough for a 20-bit sum
	assign fold1 = (LEN_W+1)'(sum_s2[LEN_W-1:0]) + (LEN_W+1)'(sum_s2[SUM_W-1:LEN_W]);
	assign fold2 = fold1[LEN_W-1:0] + LEN_W'(fold1[LEN_W]);

	always_comb begin
		q_wdata      = fld_s2;
		q_wdata.csum = ~fold2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_addr_q <= '0;
			ident_q      <= '0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
		end else begin
			if (cfg_we)
				local_addr_q <= cfg_wdata;
			if (req_xfer)
				ident_q <= ident_q + 1'b1;
			if (req.ready)
				valid_s1 <= req.valid;
			if (!valid_s2 || q_push)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			fld_s1.dest_addr       <= req.dest_addr;
			fld_s1.src_addr        <= local_addr_q;
			fld_s1.protocol_number <= req.protocol_number;
			fld_s1.pkt_len         <= plen_sat + HDR_LEN;
			fld_s1.ident           <= ident_q;
			fld_s1.csum            <= '0;
		end
		if (move_s12) begin
			fld_s2 <= fld_s1;
			sum_s2 <= sum_c;
		end
	end

	a_ident_step: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer |=> ident_q == $past(ident_q) + 1'b1)
		else $error("ident counter did not step on request transfer");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && q_full |=> valid_s2 && $stable(sum_s2))
		else $error("stage 2 lost its item while the queue was full");

endmodule

// ===== rtl/core/ipv4hg_queue.sv =====
module ipv4hg_queue #(
	parameter int Depth = ipv4hg_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ipv4hg_pkg::q_ctrl_t         ctrl,
	input  ipv4hg_pkg::hdr_entry_t      wdata,
	output ipv4hg_pkg::q_stat_t         stat,
	output ipv4hg_pkg::hdr_entry_t      rdata
);
	import ipv4hg_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	hdr_entry_t      slot_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign stat.full  = (count_q == FullCnt);
	assign stat.empty = (count_q == '0);
	assign rdata      = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (ctrl.push)
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			if (ctrl.pop)
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			if (ctrl.push && !ctrl.pop)
				count_q <= count_q + 1'b1;
			else if (ctrl.pop && !ctrl.push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push)
			slot_q[wr_ptr_q] <= wdata;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.push && stat.full))
		else $error("push into a full header queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.pop && stat.empty))
		else $error("pop from an empty header queue");

endmodule

// ===== rtl/core/ipv4hg_back.sv =====
module ipv4hg_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  ipv4hg_pkg::hdr_entry_t      q_rdata,
	output logic                        q_pop,
	ipv4hg_hdr_if.source                hdr
);
	import ipv4hg_pkg::*;

	logic [IDX_W-1:0]  idx_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic [IDX_W-1:0]  index_q;
	logic              last_q;

	logic              load;
	logic              at_last;
	logic [BYTE_W-1:0] byte_c;

	always_comb begin
		case (idx_q)
			5'd0:    byte_c = VER_IHL;
			5'd1:    byte_c = TOS;
			5'd2:    byte_c = q_rdata.pkt_len[15:8];
			5'd3:    byte_c = q_rdata.pkt_len[7:0];
			5'd4:    byte_c = q_rdata.ident[15:8];
			5'd5:    byte_c = q_rdata.ident[7:0];
			5'd6:    byte_c = FLAGS_DF[15:8];
			5'd7:    byte_c = FLAGS_DF[7:0];
			5'd8:    byte_c = TTL;
			5'd9:    byte_c = q_rdata.protocol_number;
			5'd10:   byte_c = q_rdata.csum[15:8];
			5'd11:   byte_c = q_rdata.csum[7:0];
			5'd12:   byte_c = q_rdata.src_addr[31:24];
			5'd13:   byte_c = q_rdata.src_addr[23:16];
			5'd14:   byte_c = q_rdata.src_addr[15:8];
			5'd15:   byte_c = q_rdata.src_addr[7:0];
			5'd16:   byte_c = q_rdata.dest_addr[31:24];
			5'd17:   byte_c = q_rdata.dest_addr[23:16];
			5'd18:   byte_c = q_rdata.dest_addr[15:8];
			5'd19:   byte_c = q_rdata.dest_addr[7:0];
			default: byte_c = '0;
		endcase
	end

	// output register frees up on the same cycle the receiver takes a byte
	assign load    = !q_empty && (!out_valid_q || hdr.ready);
	assign at_last = (idx_q == LAST_IDX);
	assign q_pop   = load && at_last;

	assign hdr.valid       = out_valid_q;
	assign hdr.header_byte = byte_q;
	assign hdr.byte_index  = index_q;
	assign hdr.last_byte   = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= at_last ? '0 : idx_q + 1'b1;
			if (load)
				out_valid_q <= 1'b1;
			else if (hdr.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q  <= byte_c;
			index_q <= idx_q;
			last_q  <= at_last;
		end
	end

	a_index_runs: assert property (@(posedge clk) disable iff (!arst_n)
		hdr.valid && hdr.ready && !hdr.last_byte && load
		|=> hdr.valid && hdr.byte_index == $past(hdr.byte_index) + 1'b1)
		else $error("header bytes out of sequence");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		hdr.valid |-> (hdr.last_byte == (hdr.byte_index == LAST_IDX)))
		else $error("last byte flag disagrees with byte index");

endmodule

// ===== rtl/core/ipv4_header_generator_core.sv =====
// ipv4 header generator core
// requests come in on req (dest_addr, protocol_number, payload_length) with a
// valid/ready transfer; each request yields 20 transfers on hdr, one header byte
// each, in network byte order with byte_index 0..19 and last_byte on byte 19.
// the source address comes from the local address register written through
// cfg_we/cfg_wdata; write it only while no header is in flight.
// payload_length above 65515 is clamped so total length stays within 16 bits.
// identification is a 16-bit counter, used then incremented per request.
// the first byte of a header passes the capture register at the request transfer,
// then the checksum sum register, the fold into the queue and the output register.
// throughput: one byte per cycle while the receiver is ready, set by the
// single-byte output register; a second request is taken while the first still
// streams and waits in a small queue.
// a stalled receiver holds the output byte; the queue then fills and req.ready
// drops. reset clears the address register, the counter and all valid state.
module ipv4_header_generator_core #(
	parameter int QueueDepth = ipv4hg_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ipv4hg_pkg::ADDR_W-1:0]   cfg_wdata,
	ipv4hg_req_if.sink                      req,
	ipv4hg_hdr_if.source                    hdr
);
	import ipv4hg_pkg::*;

	q_ctrl_t    q_ctrl;
	q_stat_t    q_stat;
	hdr_entry_t q_wdata;
	hdr_entry_t q_rdata;
	logic       q_push;
	logic       q_pop;

	assign q_ctrl.push = q_push;
	assign q_ctrl.pop  = q_pop;

	ipv4hg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.q_full    (q_stat.full),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	ipv4hg_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (q_ctrl),
		.wdata  (q_wdata),
		.stat   (q_stat),
		.rdata  (q_rdata)
	);

	ipv4hg_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_stat.empty),
		.q_rdata (q_rdata),
		.q_pop   (q_pop),
		.hdr     (hdr)
	);

endmodule

// ===== bench/tb_ipv4_header_generator_core.sv =====
module tb_ipv4_header_generator_core;
	import ipv4hg_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int MAX_WAIT       = 13;
	localparam int REPORT_LIMIT   = 10;

	typedef struct {
		logic [BYTE_W-1:0] hbyte;
		logic [IDX_W-1:0]  idx;
		logic              last;
	} hdr_byte_t;

	class header_scoreboard;
		logic [ADDR_W-1:0] local_addr;
		logic [LEN_W-1:0]  next_ident;
		hdr_byte_t         pending[$];
		int                fails;

		function new();
			local_addr = '0;
			next_ident = '0;
			fails      = 0;
		endfunction

		function void flag(string msg);
			if (fails < REPORT_LIMIT) begin
				$display("%s", msg);
			end
			fails++;
		endfunction

		// builds the 20 header bytes of one accepted request
		function void note_request(logic [ADDR_W-1:0] dest, logic [PROTO_W-1:0] proto,
				logic [LEN_W-1:0] plen);
			logic [BYTE_W-1:0] hb[HDR_BYTES];
			logic [LEN_W-1:0]  len;
			logic [31:0]       sum;
			hdr_byte_t         e;
			int                i;
			len = (plen > MAX_PAYLOAD) ? MAX_PAYLOAD : plen;
			len = len + HDR_LEN;
			hb[0] = VER_IHL;
			hb[1] = TOS;
			{hb[2], hb[3]} = len;
			{hb[4], hb[5]} = next_ident;
			{hb[6], hb[7]} = FLAGS_DF;
			hb[8]  = TTL;
			hb[9]  = proto;
			hb[10] = '0;
			hb[11] = '0;
			{hb[12], hb[13], hb[14], hb[15]} = local_addr;
			{hb[16], hb[17], hb[18], hb[19]} = dest;
			sum = '0;
			for (i = 0; i < HDR_BYTES; i += 2) begin
				sum = sum + {16'h0, hb[i], hb[i+1]};
			end
			// fold carries back in until the sum fits in 16 bits
			while (sum[31:16] != '0) begin
				sum = {16'h0, sum[15:0]} + {16'h0, sum[31:16]};
			end
			{hb[10], hb[11]} = ~sum[15:0];
			next_ident = next_ident + 1'b1;
			for (i = 0; i < HDR_BYTES; i++) begin
				e.hbyte = hb[i];
				e.idx   = i[IDX_W-1:0];
				e.last  = (i == HDR_BYTES - 1);
				pending.push_back(e);
			end
		endfunction

		function void check_byte(logic [BYTE_W-1:0] hbyte, logic [IDX_W-1:0] idx, logic last);
			hdr_byte_t e;
			if (pending.size() == 0) begin
				flag($sformatf("unexpected header byte %h index %0d last %b", hbyte, idx, last));
			end else begin
				e = pending.pop_front();
				if (hbyte !== e.hbyte || idx !== e.idx || last !== e.last) begin
					flag($sformatf("header byte mismatch: expected %h/%0d/%b got %h/%0d/%b",
						e.hbyte, e.idx, e.last, hbyte, idx, last));
				end
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [ADDR_W-1:0] cfg_wdata;

	ipv4hg_req_if req_if();
	ipv4hg_hdr_if hdr_if();

	header_scoreboard sb;
	bit               no_idle = 1'b0;
	bit               req_calm = 1'b0;
	int               idle_cycles = 0;

	ipv4_header_generator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_if),
		.hdr       (hdr_if)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run stops if nothing transfers for too long
	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (hdr_if.valid && hdr_if.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic send_request(input logic [ADDR_W-1:0] dest, input logic [PROTO_W-1:0] proto,
			input logic [LEN_W-1:0] plen);
		int gap;
		bit taken;
		if ($urandom_range(0, 19) == 0) begin
			req_calm = !req_calm;
		end
		gap = (req_calm || no_idle) ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid           <= 1'b1;
		req_if.dest_addr       <= dest;
		req_if.protocol_number <= proto;
		req_if.payload_length  <= plen;
		// handshake is sampled mid-cycle, where it holds the value seen by the next edge
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = req_if.valid && req_if.ready;
			@(posedge clk);
		end
		sb.note_request(dest, proto, plen);
	endtask

	// drop valid and let every queued header drain out
	task automatic settle();
		req_if.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_local_addr(input logic [ADDR_W-1:0] addr);
		cfg_we    <= 1'b1;
		cfg_wdata <= addr;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.local_addr = addr;
	endtask

	task automatic random_requests(input int count);
		logic [ADDR_W-1:0]  dest;
		logic [PROTO_W-1:0] proto;
		logic [LEN_W-1:0]   plen;
		int                 k;
		int                 sel;
		for (k = 0; k < count; k++) begin
			sel  = $urandom_range(0, 9);
			dest = $urandom;
			if (sel == 0) begin
				dest = '0;
			end else if (sel == 1) begin
				dest = '1;
			end
			proto = PROTO_W'($urandom_range(0, 255));
			case ($urandom_range(0, 5))
				0: begin
					plen = LEN_W'($urandom_range(0, 65535));
				end
				1: begin
					plen = LEN_W'($urandom_range(65500, 65535));
				end
				default: begin
					plen = LEN_W'($urandom_range(0, 1500));
				end
			endcase
			send_request(dest, proto, plen);
		end
	endtask

	initial begin : header_sink
		int                stall;
		bit                calm;
		bit                taken;
		logic [BYTE_W-1:0] hbyte;
		logic [IDX_W-1:0]  idx;
		logic              last;
		calm = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 19) == 0) begin
				calm = !calm;
			end
			stall = (calm || no_idle) ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				hdr_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			hdr_if.ready <= 1'b1;
			taken = 1'b0;
			while (!taken) begin
				@(negedge clk);
				taken = hdr_if.valid && hdr_if.ready;
				hbyte = hdr_if.header_byte;
				idx   = hdr_if.byte_index;
				last  = hdr_if.last_byte;
				@(posedge clk);
			end
			sb.check_byte(hbyte, idx, last);
		end
	end

	initial begin : stimulus
		sb                     = new();
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_wdata              = '0;
		req_if.valid           = 1'b0;
		req_if.dest_addr       = '0;
		req_if.protocol_number = '0;
		req_if.payload_length  = '0;
		hdr_if.ready           = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// source address still at its reset value here
		send_request(32'h0000_0000, 8'd0,   16'd0);
		send_request(32'hFFFF_FFFF, 8'd255, 16'hFFFF);
		send_request(32'hFFFF_FFFF, 8'd1,   16'd65515);
		send_request(32'h0000_0000, 8'd6,   16'd65516);
		send_request(32'hC0A8_0001, 8'd17,  16'd20);
		send_request(32'h0A00_0001, 8'd6,   16'd1);
		send_request(32'hFFFF_FFFF, 8'd255, 16'd65514);
		send_request(32'h8000_0000, 8'd128, 16'h8000);
		send_request(32'h0000_0001, 8'd1,   16'h7FFF);
		send_request(32'h5555_5555, 8'h55,  16'h5555);
		send_request(32'hAAAA_AAAA, 8'hAA,  16'hAAAA);
		settle();

		write_local_addr(32'hFFFF_FFFF);
		send_request(32'hFFFF_FFFF, 8'd255, 16'hFFFF);
		send_request(32'hFFFF_FFFF, 8'd0,   16'd65515);
		send_request(32'h0000_0000, 8'd6,   16'd0);
		random_requests(30);
		settle();

		write_local_addr(32'h0000_0000);
		random_requests(30);
		settle();

		write_local_addr($urandom);
		random_requests(50);
		settle();

		// back to back burst with no idle cycles on either side
		write_local_addr(32'hC0A8_0001);
		no_idle = 1'b1;
		random_requests(10);
		no_idle = 1'b0;
		random_requests(10);
		settle();

		if (sb.fails == 0 && sb.pending.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/ipv4hg_pkg.sv
rtl/core/ipv4hg_ifs.sv
rtl/core/ipv4hg_front.sv
rtl/core/ipv4hg_queue.sv
rtl/core/ipv4hg_back.sv
rtl/core/ipv4_header_generator_core.sv
bench/tb_ipv4_header_generator_core.sv
